### sv/mavf_pkg.sv
// ----------------------------------------------------------------------------
// mavf_pkg
// Shared types and constants of the moving average filter.
// ----------------------------------------------------------------------------
package mavf_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int FRAC_BITS  = 8;
  localparam int AVG_W      = 32;
  localparam int CNT_OUT_W  = 7;
  localparam int CFG_LEN_W  = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_LEN_W-1:0] LEN_RESET = 7'd20;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_ONLY   = 4'd1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_FILL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_SUB,
    ST_ADD,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } mavf_state_e;

endpackage

### sv/mavf_div.sv
// ----------------------------------------------------------------------------
// mavf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavf_div #(
  parameter int DVW = 39,
  parameter int NW  = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [NW-1:0]  divisor_i,
  output logic           done_o,
  output logic [DVW-1:0] quotient_o
);

  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW:0]     rem_q;
  logic [DVW-1:0]  quo_q;
  logic [NW-1:0]   div_q;
  logic [NW:0]     rem_sh;
  logic            fits;

  // The partial remainder stays below the divisor, so NW+1 bits hold the shift.
  assign rem_sh = {rem_q[NW-1:0], quo_q[DVW-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DVW);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
        quo_q <= {quo_q[DVW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### sv/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average with a sample ring, running sum and serial divider.
// ----------------------------------------------------------------------------
// Input words carry func and sample and are taken when in_valid_i is high and
// in_stall_o is low. Each input word yields exactly one output word
// (average in Q.8, fill_count, updated), held on the output until it is
// taken with out_valid_o high and out_stall_i low.
// The block works on one word at a time and stalls its input meanwhile.
// A push steps through read, subtract, add, divider start and divide, and the
// restoring divider produces one quotient bit per cycle for the DVW =
// SAMPLE_BITS + clog2(WINDOW_MAX+1) + 8 bits of its quotient. The result reaches
// the output in the same cycle as the input is free again.
// A fill writes the ring one entry per cycle, for the effective window length.
// A repeated sample pushed in change-only mode goes straight to the done state.
// The input is free again as soon as the result has moved into the output
// register, so a new word can be taken while the previous result waits.
// A stalled output holds the word and the block waits before loading the next.
// Reset empties the window, clears the last average and last sample, and sets
// the window length to 20. Writing the window length empties the window.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i.
module moving_average_filter #(
  parameter int WINDOW_MAX  = mavf_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mavf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mavf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mavf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mavf_pkg::AVG_W-1:0] average_o,
  output logic [mavf_pkg::CNT_OUT_W-1:0]    fill_count_o,
  output logic                              updated_o
);

  import mavf_pkg::*;

  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int DVW  = SUMW + FRAC_BITS;

  mavf_state_e state_q, state_d;

  logic [CFG_LEN_W-1:0]          cfg_len_q;
  logic                          cfg_chg_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [SAMPLE_BITS-1:0] last_smp_q;
  logic signed [AVG_W-1:0]       last_avg_q;
  logic                          upd_q;
  logic [AW-1:0]                 head_q;
  logic [CW-1:0]                 held_q;
  logic signed [SUMW-1:0]        sum_q;
  logic [AW-1:0]                 fill_idx_q;
  logic                          neg_q;

  logic                          out_valid_q;
  logic signed [AVG_W-1:0]       out_avg_q;
  logic [CNT_OUT_W-1:0]          out_cnt_q;
  logic                          out_upd_q;

  logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_q;

  logic [CW-1:0]          eff_len;
  logic                   accept;
  logic                   repeat_hit;
  logic                   fill_last;
  logic                   out_free;
  logic                   out_load;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic                   sum_en;
  logic signed [SUMW-1:0] add_b;
  logic signed [SUMW-1:0] sum_add;
  logic [SUMW-1:0]        sum_mag;
  logic                   div_start;
  logic [DVW-1:0]         div_dividend;
  logic                   div_done;
  logic [DVW-1:0]         div_quo;
  logic [AVG_W-1:0]       avg_mag;
  logic [CW-1:0]          head_next;

  // A length of zero acts as one; lengths above the ring depth are clamped.
  always_comb begin
    if (cfg_len_q == '0) begin
      eff_len = CW'(1);
    end else if (32'(cfg_len_q) > WINDOW_MAX) begin
      eff_len = CW'(WINDOW_MAX);
    end else begin
      eff_len = CW'(cfg_len_q);
    end
  end

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign repeat_hit = cfg_chg_q && (sample_i == last_smp_q);
  assign fill_last  = CW'(fill_idx_q) == (eff_len - 1'b1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;
  assign head_next  = CW'(head_q) + 1'b1;
  assign sum_add    = sum_q + add_b;
  assign sum_mag    = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign div_dividend = (DVW'(sum_mag) << FRAC_BITS) + DVW'(held_q >> 1);
  assign avg_mag    = AVG_W'(div_quo);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_FILL) begin
            state_d = ST_FILL;
          end else if (repeat_hit) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ:   state_d = ST_SUB;
      ST_SUB:    state_d = ST_ADD;
      ST_ADD:    state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls: the single adder serves the fill, the removal of the
  // oldest sample and the addition of the new one.
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = head_q;
    sum_en     = 1'b0;
    add_b      = SUMW'(smp_q);
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx_q;
        sum_en    = 1'b1;
      end
      ST_SUB: begin
        mem_we = 1'b1;
        add_b  = -SUMW'(rd_q);
        sum_en = held_q >= eff_len;
      end
      ST_ADD:    sum_en = 1'b1;
      ST_DSTART: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The ring is read at the head every cycle; the data is used in ST_SUB.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= smp_q;
    end
    rd_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q   <= LEN_RESET;
      cfg_chg_q   <= 1'b0;
      smp_q       <= '0;
      last_smp_q  <= '0;
      last_avg_q  <= '0;
      upd_q       <= 1'b0;
      head_q      <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      fill_idx_q  <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_avg_q   <= '0;
      out_cnt_q   <= '0;
      out_upd_q   <= 1'b0;
    end else begin
      if (sum_en) begin
        sum_q <= sum_add;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            smp_q      <= sample_i;
            fill_idx_q <= '0;
            if (func_i == FUNC_FILL) begin
              sum_q <= '0;
            end else if (repeat_hit) begin
              upd_q <= 1'b0;
            end else begin
              if (cfg_chg_q) begin
                last_smp_q <= sample_i;
              end
              if (CW'(head_q) >= eff_len) begin
                head_q <= '0;
              end
            end
          end
        end
        ST_FILL: begin
          fill_idx_q <= fill_idx_q + 1'b1;
          if (fill_last) begin
            held_q     <= eff_len;
            head_q     <= '0;
            upd_q      <= 1'b1;
            // The mean of a uniform window is the sample itself.
            last_avg_q <= AVG_W'(smp_q) <<< FRAC_BITS;
          end
        end
        ST_SUB: begin
          if (held_q >= eff_len) begin
            held_q <= eff_len;
          end else begin
            held_q <= held_q + 1'b1;
          end
        end
        ST_ADD: begin
          head_q <= (head_next >= eff_len) ? '0 : AW'(head_next);
        end
        ST_DSTART: neg_q <= sum_q[SUMW-1];
        ST_DIV: begin
          if (div_done) begin
            upd_q      <= 1'b1;
            last_avg_q <= neg_q ? -$signed(avg_mag) : $signed(avg_mag);
          end
        end
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
        out_avg_q   <= last_avg_q;
        out_cnt_q   <= CNT_OUT_W'(held_q);
        out_upd_q   <= upd_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_LENGTH: begin
            cfg_len_q <= cfg_wdata_i[CFG_LEN_W-1:0];
            head_q    <= '0;
            held_q    <= '0;
            sum_q     <= '0;
          end
          REG_CHANGE_ONLY: cfg_chg_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  mavf_div #(
    .DVW(DVW),
    .NW (CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (held_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign out_valid_o  = out_valid_q;
  assign average_o    = out_avg_q;
  assign fill_count_o = out_cnt_q;
  assign updated_o    = out_upd_q;

endmodule

### tb/moving_average_filter_test.sv
// ----------------------------------------------------------------------------
// moving_average_filter_test
// Self-checking testbench for the boxcar moving average filter.
// ----------------------------------------------------------------------------
// A behavioral copy of the filter predicts every output word from the input
// words that the block accepts. Directed tests cover reset defaults, window
// length extremes, change-only mode and fill. A long random test follows,
// with random idle cycles on both handshakes and random register settings.
// ----------------------------------------------------------------------------
module moving_average_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mavf_pkg::*;

  localparam int WMAX  = WINDOW_MAX_DEF;
  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam int EXP_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef logic signed [SBITS-1:0] sample_t;

  typedef struct packed {
    logic [AVG_W-1:0]     average;
    logic [CNT_OUT_W-1:0] fill_count;
    logic                 updated;
  } filter_out_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic                          func_i      = FUNC_PUSH;
  sample_t                       sample_i    = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [AVG_W-1:0]       average_o;
  logic [CNT_OUT_W-1:0]          fill_count_o;
  logic                          updated_o;

  moving_average_filter #(
    .WINDOW_MAX (WMAX),
    .SAMPLE_BITS(SBITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .fill_count_o(fill_count_o),
    .updated_o   (updated_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Behavioral copy of the filter state and registers.
  sample_t                ring [WMAX];
  int                     ring_head     = 0;
  int                     held          = 0;
  longint                 window_sum    = 0;
  sample_t                last_sample   = '0;
  logic [AVG_W-1:0]       last_avg      = '0;
  logic [CFG_LEN_W-1:0]   window_reg    = LEN_RESET;
  logic                   change_only_q = 1'b0;

  // Expected words in order, kept in a small ring with running counters.
  filter_out_t pending_results [EXP_DEPTH];
  int          exp_wr     = 0;
  int          exp_rd     = 0;
  int          mismatches = 0;
  bit          no_idle    = 1'b0;
  sample_t     prev_sample = '0;

  function automatic int window_span();
    if (window_reg == 0) return 1;
    if (window_reg > WMAX) return WMAX;
    return int'(window_reg);
  endfunction

  // Mean in Q.8, rounded to nearest with ties away from zero.
  function automatic logic [AVG_W-1:0] q8_mean(longint total, int n);
    longint unsigned mag;
    longint unsigned q;
    longint unsigned signed_q;
    mag = (total < 0) ? longint'(-total) : longint'(total);
    q = ((mag << FRAC_BITS) + longint'(n / 2)) / longint'(n);
    signed_q = (total < 0) ? -q : q;
    return signed_q[AVG_W-1:0];
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_WINDOW_LENGTH) begin
      window_reg = data[CFG_LEN_W-1:0];
      ring_head  = 0;
      held       = 0;
      window_sum = 0;
    end else if (idx == REG_CHANGE_ONLY) begin
      change_only_q = data[0];
    end
  endfunction

  function automatic filter_out_t filter_step(logic fn, sample_t s);
    filter_out_t r;
    int n;
    n = window_span();
    if (fn == FUNC_FILL) begin
      for (int i = 0; i < n; i++) ring[i] = s;
      ring_head  = 0;
      held       = n;
      window_sum = longint'(s) * n;
      last_avg   = q8_mean(window_sum, held);
      r = '{average: last_avg, fill_count: CNT_OUT_W'(held), updated: 1'b1};
      return r;
    end
    if (change_only_q && s == last_sample) begin
      r = '{average: last_avg, fill_count: CNT_OUT_W'(held), updated: 1'b0};
      return r;
    end
    if (change_only_q) last_sample = s;
    if (ring_head >= n) ring_head = 0;
    if (held >= n) begin
      window_sum -= ring[ring_head];
      held = n;
    end else begin
      held++;
    end
    ring[ring_head] = s;
    window_sum += s;
    ring_head = (ring_head + 1 >= n) ? 0 : ring_head + 1;
    last_avg = q8_mean(window_sum, held > 0 ? held : 1);
    r = '{average: last_avg, fill_count: CNT_OUT_W'(held), updated: 1'b1};
    return r;
  endfunction

  // Sends one word and records its expected result once it is taken.
  task automatic send_word(logic fn, sample_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    pending_results[exp_wr % EXP_DEPTH] = filter_step(fn, s);
    exp_wr++;
    prev_sample = s;
  endtask

  // Lowers valid and waits until every expected word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_wr != exp_rd);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic configure(logic [CFG_LEN_W-1:0] len, logic co);
    drain();
    write_reg(REG_WINDOW_LENGTH, len);
    // Upper data bits of the change-only register are don't-care.
    write_reg(REG_CHANGE_ONLY, {(CFG_DATA_W-1)'($urandom()), co});
  endtask

  // Reset defaults: window length 20, change-only off.
  task automatic test_reset_defaults();
    send_word(FUNC_PUSH, sample_t'(8388607));
    send_word(FUNC_PUSH, sample_t'(-8388608));
    send_word(FUNC_PUSH, sample_t'(0));
    send_word(FUNC_PUSH, sample_t'(-1));
    send_word(FUNC_PUSH, sample_t'(1));
  endtask

  task automatic test_window_extremes();
    configure(7'd1, 1'b0);
    send_word(FUNC_PUSH, sample_t'(-3));
    send_word(FUNC_PUSH, sample_t'(8388607));
    configure(7'd64, 1'b0);
    send_word(FUNC_FILL, sample_t'(8388607));
    send_word(FUNC_PUSH, sample_t'(-8388608));
    // A length of zero behaves as one, anything above the maximum as the maximum.
    configure(7'd0, 1'b0);
    send_word(FUNC_PUSH, sample_t'(5));
    configure(7'h7F, 1'b0);
    send_word(FUNC_FILL, sample_t'(-8388608));
    send_word(FUNC_PUSH, sample_t'(3));
  endtask

  task automatic test_change_only();
    configure(7'd3, 1'b1);
    send_word(FUNC_PUSH, sample_t'(0));
    send_word(FUNC_PUSH, sample_t'(5));
    send_word(FUNC_PUSH, sample_t'(5));
    send_word(FUNC_FILL, sample_t'(5));
    send_word(FUNC_PUSH, sample_t'(-7));
    // Emptying the window keeps the last sample and the last average.
    drain();
    write_reg(REG_WINDOW_LENGTH, 7'd2);
    write_reg(REG_UNUSED, 7'h55);
    send_word(FUNC_PUSH, sample_t'(-7));
    send_word(FUNC_PUSH, sample_t'(-8));
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1:    return prev_sample;
      2, 3:    return sample_t'($urandom_range(0, 6)) - sample_t'(3);
      4:       return $urandom_range(0, 1) ? sample_t'(8388607) : sample_t'(-8388608);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic test_random();
    logic [CFG_LEN_W-1:0] len;
    for (int phase = 0; phase < 17; phase++) begin
      case ($urandom_range(0, 9))
        0:       len = 7'd0;
        1:       len = 7'd64;
        2:       len = 7'h7F;
        3:       len = CFG_LEN_W'($urandom_range(65, 127));
        4, 5:    len = CFG_LEN_W'($urandom_range(1, 64));
        default: len = CFG_LEN_W'($urandom_range(1, 8));
      endcase
      drain();
      if (phase == 0 || $urandom_range(0, 9) < 7) write_reg(REG_WINDOW_LENGTH, len);
      write_reg(REG_CHANGE_ONLY, {(CFG_DATA_W-1)'($urandom()), 1'($urandom())});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
      no_idle = (phase == 2 || phase == 9);
      for (int k = 0; k < 50; k++) begin
        if (phase == 5 && k == 25) drain();
        send_word(($urandom_range(0, 11) == 0) ? FUNC_FILL : FUNC_PUSH, pick_sample());
      end
    end
    no_idle = 1'b0;
  endtask

  // Output side: random stall, then take and check one word.
  initial begin
    int n;
    filter_out_t want;
    wait (rst_ni === 1'b1);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 6);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (exp_wr == exp_rd) begin
        $error("unexpected output word: average %0d", average_o);
        mismatches++;
      end else begin
        want = pending_results[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (average_o !== want.average) begin
          $error("average: expected %0d, got %0d", $signed(want.average), average_o);
          mismatches++;
        end
        if (fill_count_o !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count_o);
          mismatches++;
        end
        if (updated_o !== want.updated) begin
          $error("updated: expected %0d, got %0d", want.updated, updated_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_window_extremes();
    test_change_only();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
